FILE: src/pedal_sensor_plausibility_defines.svh
// assertion macros for the pedal sensor plausibility rtl
// expects clk and rst_n in the scope of each use
`ifndef PEDAL_SENSOR_PLAUSIBILITY_DEFINES_SVH
`define PEDAL_SENSOR_PLAUSIBILITY_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pedal sensor plausibility: same-cycle check failed");

// next-cycle implication, checked out of reset
`define PSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pedal sensor plausibility: next-cycle check failed");

`endif

FILE: src/psp_pkg.sv
// package for the pedal sensor plausibility block
// widths, register codes, command and status structs, divide-by-ten helper
`timescale 1ns / 1ps

package psp_pkg;

    localparam int unsigned ADC_FULL_SCALE_DEF = 4095;

    localparam int SENSOR_W   = 12;
    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 12;
    localparam int TOL_W      = 11;
    localparam int TIMEOUT_W  = 16;
    localparam int PCT_W      = 7;
    localparam int PML_W      = 10;
    localparam int BOUND_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // permille scaling and divider sizing
    localparam int              PML_SCALE_W = 10;
    localparam logic [PML_W-1:0] PML_SCALE  = 10'd1000;
    localparam logic [PML_W-1:0] PML_MAX    = 10'd1000;
    localparam int NUM_W      = LEVEL_W + PML_SCALE_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // x / 10 as (x * 205) >> 11, exact for x below 1029
    localparam int DIV10_PROD_W = PML_W + 8;
    localparam int DIV10_MUL    = 205;
    localparam int DIV10_SHIFT  = 11;

    // register reset values
    localparam logic [SENSOR_W-1:0]  MIN_LEVEL_RST = 12'd0;
    localparam logic [SENSOR_W-1:0]  MAX_LEVEL_RST = 12'd4095;
    localparam logic [TOL_W-1:0]     TOLERANCE_RST = 11'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_LEVEL,
        REG_MAX_LEVEL,
        REG_TOLERANCE,
        REG_TIMEOUT
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LEVEL,
        S_MUL,
        S_DIV,
        S_FINISH
    } psp_state_t;

    typedef struct packed {
        logic capture;
        logic check;
        logic level;
        logic mul_load;
        logic div_step;
        logic load_out;
    } psp_cmd_t;

    typedef struct packed {
        logic ok;
        logic region_zero;
    } psp_status_t;

    function automatic logic [PCT_W-1:0] div10(input logic [PML_W-1:0] x);
        logic [DIV10_PROD_W-1:0] prod;
        prod = DIV10_PROD_W'(x) * DIV10_PROD_W'(DIV10_MUL);
        return prod[DIV10_SHIFT +: PCT_W];
    endfunction

endpackage

FILE: src/pedal_sensor_plausibility.sv
// top level of the dual pedal sensor plausibility check; uses psp_pkg, psp_ctrl, psp_datapath
// sequence: a passing sample with a non-zero region goes through check, level, multiply,
//   22 divider steps and the output load; a failing or zero-region sample skips to the load
// one item at a time: a new item is taken only once the previous one is in the output register
// reset: config registers to 0 / 4095 / 0 / 100, persistence timer cleared, no result pending
`timescale 1ns / 1ps

module pedal_sensor_plausibility #(
    // full scale of the reversed sensor, used for its inversion
    parameter int unsigned ADC_FULL_SCALE = psp_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input item channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [psp_pkg::SENSOR_W-1:0]       sensor_a,
    input  logic [psp_pkg::SENSOR_W-1:0]       sensor_b,
    input  logic [psp_pkg::TIME_W-1:0]         now_ms,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [psp_pkg::LEVEL_W-1:0]        pedal_level,
    output logic [psp_pkg::PCT_W-1:0]          percent,
    output logic [psp_pkg::PML_W-1:0]          permille,
    output logic                               implausible,
    output logic                               fault,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import psp_pkg::*;

    psp_cmd_t    cmd;
    psp_status_t status;
    logic        cfg_we;

    // register writes are always taken; the user must issue them only while the block is idle, not enforced here
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencer: one item at a time, the output register holds a finished result
    // so the next item can be taken before the previous transfer completes
    psp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: inversion and checks, persistence timer, level * 1000 and a
    // restoring divide by the functional region, percent taken from permille
    psp_datapath #(
        .ADC_FULL_SCALE (ADC_FULL_SCALE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sensor_a    (sensor_a),
        .sensor_b    (sensor_b),
        .now_ms      (now_ms),
        .pedal_level (pedal_level),
        .percent     (percent),
        .permille    (permille),
        .implausible (implausible),
        .fault       (fault)
    );

endmodule

FILE: src/psp_ctrl.sv
// sequencer for the pedal sensor plausibility block
// depends on psp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "pedal_sensor_plausibility_defines.svh"

module psp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  psp_pkg::psp_status_t  status,
    output psp_pkg::psp_cmd_t     cmd
);
    import psp_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    psp_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                cmd.level = 1'b1;
                if (!status.ok || status.region_zero)
                    state_next = S_FINISH;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    `PSP_ASSERT_NEXT(a_accept_starts_check, in_valid && in_ready, state_reg == S_CHECK)
    `PSP_ASSERT_NEXT(a_fail_skips_divider, state_reg == S_LEVEL && !status.ok,
                     state_reg == S_FINISH)
    `PSP_ASSERT_NEXT(a_divider_ends, state_reg == S_DIV && div_cnt_reg == DIV_LAST,
                     state_reg == S_FINISH)
    `PSP_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_valid_reg)
    `PSP_ASSERT_SAME(a_no_load_over_pending, out_valid_reg && !out_ready, !cmd.load_out)

endmodule

FILE: src/psp_datapath.sv
// datapath for the pedal sensor plausibility block: config registers,
// checks, persistence timer, scaling multiply, restoring divider, output register
// depends on psp_pkg
`timescale 1ns / 1ps

module psp_datapath #(
    parameter int unsigned ADC_FULL_SCALE = psp_pkg::ADC_FULL_SCALE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  psp_pkg::psp_cmd_t                  cmd,
    output psp_pkg::psp_status_t               status,
    input  logic                               cfg_we,
    input  logic [psp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [psp_pkg::SENSOR_W-1:0]       sensor_a,
    input  logic [psp_pkg::SENSOR_W-1:0]       sensor_b,
    input  logic [psp_pkg::TIME_W-1:0]         now_ms,
    output logic [psp_pkg::LEVEL_W-1:0]        pedal_level,
    output logic [psp_pkg::PCT_W-1:0]          percent,
    output logic [psp_pkg::PML_W-1:0]          permille,
    output logic                               implausible,
    output logic                               fault
);
    import psp_pkg::*;

    localparam int B_W  = $clog2(ADC_FULL_SCALE + 1);
    localparam int VW   = (B_W > BOUND_W) ? B_W : BOUND_W;
    localparam int MW   = ((B_W + 4) > 16) ? (B_W + 4) : 16;
    localparam int FS_W = 17;

    // configuration
    logic [SENSOR_W-1:0]  min_level_reg;
    logic [SENSOR_W-1:0]  max_level_reg;
    logic [TOL_W-1:0]     tolerance_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // persistence state
    logic              error_pending_reg;
    logic [TIME_W-1:0] error_start_reg;

    // captured item
    logic [SENSOR_W-1:0] a_reg, braw_reg;
    logic [TIME_W-1:0]   now_reg;

    // check stage results
    logic                ok_reg;
    logic                fault_cand_reg;
    logic [VW-1:0]       mean_reg;
    logic [LEVEL_W-1:0]  lo_reg, hi_reg;

    // level stage results
    logic                fault_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  region_reg;

    // divider
    logic [NUM_W-1:0]    num_reg;
    logic [LEVEL_W-1:0]  rem_reg;

    // output register
    logic [LEVEL_W-1:0]  pedal_level_reg;
    logic [PCT_W-1:0]    percent_reg;
    logic [PML_W-1:0]    permille_reg;
    logic                implausible_reg, fault_out_reg;

    logic [FS_W-1:0]     braw_w, fs_w, b_full;
    logic [B_W-1:0]      b_inv;
    logic [BOUND_W-1:0]  lo, hi_s;
    logic                hi_neg;
    logic [VW-1:0]       a_v, b_v, lo_v, hi_v;
    logic                a_in, b_in, agree;
    logic [MW-1:0]       a10, b9, b11;
    logic [VW:0]         sum;
    logic [VW-1:0]       level_full;
    logic [TIME_W-1:0]   elapsed;
    logic [LEVEL_W:0]    rem_sh;
    logic [LEVEL_W+1:0]  diff;
    logic [PML_W-1:0]    pml_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_level_reg <= MIN_LEVEL_RST;
            max_level_reg <= MAX_LEVEL_RST;
            tolerance_reg <= TOLERANCE_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_LEVEL: min_level_reg <= cfg_data[SENSOR_W-1:0];
                REG_MAX_LEVEL: max_level_reg <= cfg_data[SENSOR_W-1:0];
                REG_TOLERANCE: tolerance_reg <= cfg_data[TOL_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // inverted second sensor, saturating at zero
    always_comb
    begin
        braw_w = FS_W'(braw_reg);
        fs_w   = FS_W'(ADC_FULL_SCALE);
        b_full = (braw_w > fs_w) ? '0 : (fs_w - braw_w);
        b_inv  = b_full[B_W-1:0];
    end

    // window bounds
    assign lo     = BOUND_W'(min_level_reg) + BOUND_W'(tolerance_reg);
    assign hi_s   = BOUND_W'(max_level_reg) - BOUND_W'(tolerance_reg);
    assign hi_neg = (tolerance_reg > TOL_W'(0)) &&
                    (BOUND_W'(tolerance_reg) > BOUND_W'(max_level_reg));

    assign a_v  = VW'(a_reg);
    assign b_v  = VW'(b_inv);
    assign lo_v = VW'(lo);
    assign hi_v = VW'(hi_s[LEVEL_W-1:0]);

    assign a_in = !hi_neg && (a_v >= lo_v) && (a_v <= hi_v);
    assign b_in = !hi_neg && (b_v >= lo_v) && (b_v <= hi_v);

    // ten percent agreement
    assign a10   = (MW'(a_reg) << 3) + (MW'(a_reg) << 1);
    assign b9    = (MW'(b_inv) << 3) + MW'(b_inv);
    assign b11   = (MW'(b_inv) << 3) + (MW'(b_inv) << 1) + MW'(b_inv);
    assign agree = (a10 >= b9) && (a10 <= b11);

    assign sum     = (VW + 1)'(a_v) + (VW + 1)'(b_v);
    assign elapsed = now_reg - error_start_reg;

    assign level_full = mean_reg - VW'(min_level_reg);

    // restoring divider step
    assign rem_sh = {rem_reg, num_reg[NUM_W-1]};
    assign diff   = (LEVEL_W + 2)'(rem_sh) - (LEVEL_W + 2)'(region_reg);

    assign pml_c = (num_reg > NUM_W'(PML_MAX)) ? PML_MAX : num_reg[PML_W-1:0];

    assign status.ok          = ok_reg;
    assign status.region_zero = (hi_reg == lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_pending_reg <= 1'b0;
            error_start_reg   <= '0;
            ok_reg            <= 1'b0;
        end
        else
        begin
            if (cmd.check)
                ok_reg <= agree && a_in && b_in;
            if (cmd.level)
            begin
                if (!ok_reg)
                begin
                    if (!error_pending_reg)
                    begin
                        error_start_reg   <= now_reg;
                        error_pending_reg <= 1'b1;
                    end
                end
                else
                begin
                    error_start_reg   <= '0;
                    error_pending_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg    <= sensor_a;
            braw_reg <= sensor_b;
            now_reg  <= now_ms;
        end
        if (cmd.check)
        begin
            mean_reg       <= sum[VW:1];
            lo_reg         <= lo[LEVEL_W-1:0];
            hi_reg         <= hi_s[LEVEL_W-1:0];
            fault_cand_reg <= elapsed > TIME_W'(timeout_reg);
        end
        if (cmd.level)
        begin
            level_reg  <= level_full[LEVEL_W-1:0];
            region_reg <= hi_reg - lo_reg;
            fault_reg  <= !ok_reg && error_pending_reg && fault_cand_reg;
        end
        if (cmd.mul_load)
        begin
            num_reg <= NUM_W'(level_reg) * NUM_W'(PML_SCALE);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!diff[LEVEL_W+1])
                rem_reg <= diff[LEVEL_W-1:0];
            else
                rem_reg <= rem_sh[LEVEL_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], !diff[LEVEL_W+1]};
        end
        if (cmd.load_out)
        begin
            pedal_level_reg <= ok_reg ? level_reg : '0;
            permille_reg    <= (ok_reg && !status.region_zero) ? pml_c : '0;
            percent_reg     <= (ok_reg && !status.region_zero) ? div10(pml_c) : '0;
            implausible_reg <= !ok_reg;
            fault_out_reg   <= fault_reg;
        end
    end

    assign pedal_level = pedal_level_reg;
    assign percent     = percent_reg;
    assign permille    = permille_reg;
    assign implausible = implausible_reg;
    assign fault       = fault_out_reg;

endmodule
